// File: rtl/plc_pkg.sv
// Package for the positional list: request and status codes, cell control word.
// No dependencies; used by plc_cell and positional_list_append_read_remove_top.
package plc_pkg;

	localparam int CNT_W = 9;

	typedef enum logic [1:0] {
		REQ_APPEND = 2'd0,
		REQ_READ   = 2'd1,
		REQ_REMOVE = 2'd2
	} req_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_BAD_POS = 2'd1,
		ST_EMPTY   = 2'd2,
		ST_FULL    = 2'd3
	} stat_t;

	typedef struct packed {
		logic             app_en;
		logic             rem_en;
		logic             rd_en;
		logic [CNT_W-1:0] pidx;
		logic [CNT_W-1:0] cnt;
	} cell_ctl_t;

endpackage

// File: rtl/plc_cell.sv
// One entry cell of the positional list: loads on append, takes its right
// neighbor's word on remove, drives its word onto the read bus when selected. Uses plc_pkg.
module plc_cell import plc_pkg::*; #(
	parameter int W   = 16,
	parameter int IDX = 0
) (
	input  logic             clk,
	input  cell_ctl_t        ctl,
	input  logic [W-1:0]     wr_d,
	input  logic [W-1:0]     nbr_d,
	output logic [W-1:0]     d,
	output logic [W-1:0]     rd
);

	localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);
	localparam logic [CNT_W-1:0] NXT_C = CNT_W'(IDX + 1);

	logic [W-1:0] data_q;
	logic         load;
	logic         shift;

	assign load  = ctl.app_en && (IDX_C == ctl.cnt);
	assign shift = ctl.rem_en && (IDX_C >= ctl.pidx) && (NXT_C < ctl.cnt);

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= wr_d;
		end else if (shift) begin
			data_q <= nbr_d;
		end
	end

	assign d  = data_q;
	assign rd = (ctl.rd_en && (IDX_C == ctl.pidx)) ? data_q : '0;

endmodule

// File: rtl/positional_list_append_read_remove_top.sv
// Positional list top: request decode, entry count, row of plc_cell, result register.
// Depends on plc_pkg and plc_cell.
//
//  channel   | handshake            | words
//  ----------+----------------------+-------------------------------------------
//  request   | start / busy         | req_type, position, item_handle
//  result    | done (one cycle)     | status, read_handle, entry_count
//
// Each request is handled in the cell row; its result shows on the cycle
// after acceptance, and a new request may be accepted every cycle (busy stays low).
// An append, a read and a remove are each done in place: every cell decides
// locally whether to load, shift from its neighbor or drive the read bus.
// Reset clears the entry count and the result strobe; entry contents are not reset.
// The receiver cannot stall, so no result is ever held back.
module positional_list_append_read_remove_top import plc_pkg::*; #(
	parameter int CAPACITY    = 64,
	parameter int HANDLE_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  req_type,
	input  logic [7:0]  position,
	input  logic [15:0] item_handle,
	output logic        done,
	output logic [1:0]  status,
	output logic [15:0] read_handle,
	output logic [6:0]  entry_count
);

	localparam int SW = (HANDLE_BITS < 16) ? HANDLE_BITS : 16;
	localparam int CW = $clog2(CAPACITY + 1);

	logic [CW-1:0]    count_q;
	logic [CW-1:0]    count_nxt;
	logic             accept;
	stat_t            stat;
	cell_ctl_t        ctl;
	logic [CNT_W-1:0] cnt_x;
	logic [CNT_W-1:0] pos_x;
	logic [SW-1:0]    wr_d;
	logic [SW-1:0]    cell_d  [CAPACITY];
	logic [SW-1:0]    cell_rd [CAPACITY];
	logic [SW-1:0]    rd_bus;

	logic             done_q;
	stat_t            status_q;
	logic [15:0]      read_handle_q;
	logic [6:0]       entry_count_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign cnt_x  = CNT_W'(count_q);
	assign pos_x  = CNT_W'(position);
	assign wr_d   = item_handle[SW-1:0];

	always_comb begin
		stat       = ST_OK;
		ctl.app_en = 1'b0;
		ctl.rem_en = 1'b0;
		ctl.rd_en  = 1'b0;
		ctl.pidx   = pos_x - CNT_W'(1);
		ctl.cnt    = cnt_x;
		count_nxt  = count_q;
		unique case (req_t'(req_type)) inside
			REQ_APPEND: begin
				if (cnt_x >= CNT_W'(CAPACITY)) begin
					stat = ST_FULL;
				end else begin
					ctl.app_en = accept;
					count_nxt  = count_q + CW'(1);
				end
			end
			REQ_READ, REQ_REMOVE: begin
				if (count_q == '0) begin
					stat = ST_EMPTY;
				end else if (position == '0 || pos_x > cnt_x) begin
					stat = ST_BAD_POS;
				end else if (req_t'(req_type) == REQ_READ) begin
					ctl.rd_en = 1'b1;
				end else begin
					ctl.rem_en = accept;
					count_nxt  = count_q - CW'(1);
				end
			end
			default: begin
				stat = ST_BAD_POS;
			end
		endcase
	end

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		plc_cell #(.W(SW), .IDX(g)) u_cell (
			.clk   (clk),
			.ctl   (ctl),
			.wr_d  (wr_d),
			.nbr_d (cell_d[(g + 1 < CAPACITY) ? g + 1 : g]),
			.d     (cell_d[g]),
			.rd    (cell_rd[g])
		);
	end

	always_comb begin
		rd_bus = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_bus = rd_bus | cell_rd[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= accept;
			if (accept) begin
				count_q <= count_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q      <= stat;
			read_handle_q <= 16'(rd_bus);
			entry_count_q <= 7'(count_nxt);
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign read_handle = read_handle_q;
	assign entry_count = entry_count_q;

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done_q)
		else $error("result strobe missing after accepted request");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CNT_W'(count_q) <= CNT_W'(CAPACITY))
		else $error("entry count beyond capacity");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(count_q))
		else $error("entry count moved without a request");

	a_handle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q != ST_OK) |-> (read_handle_q == '0))
		else $error("read handle nonzero on failed request");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q == ST_FULL) |-> (CNT_W'(count_q) == CNT_W'(CAPACITY)))
		else $error("full status with room left");

endmodule

// File: tb/tb_positional_list_append_read_remove_top.sv
// Self-checking testbench for positional_list_append_read_remove_top.
// Depends on plc_pkg and the RTL; a tracker class predicts each result word and checks it.

class list_tracker #(int DEPTH = 64, int HBITS = 16);

	typedef struct {
		plc_pkg::stat_t st;
		logic [15:0]    hdl;
		logic [6:0]     cnt;
	} outcome_t;

	logic [15:0] slots[DEPTH];
	int          held;
	outcome_t    waiting[$];
	int          bad;

	function new();
		held = 0;
		bad  = 0;
	endfunction

	function int outstanding();
		return waiting.size();
	endfunction

	function void note(logic [1:0] rq, logic [7:0] ps, logic [15:0] hd);
		outcome_t o;
		o.st  = plc_pkg::ST_OK;
		o.hdl = '0;
		case (rq) inside
			plc_pkg::REQ_APPEND: begin
				if (held >= DEPTH) begin
					o.st = plc_pkg::ST_FULL;
				end else begin
					slots[held] = hd & ~(16'hFFFF << HBITS);
					held++;
				end
			end
			plc_pkg::REQ_READ, plc_pkg::REQ_REMOVE: begin
				if (held == 0) begin
					o.st = plc_pkg::ST_EMPTY;
				end else if (ps == 0 || ps > held) begin
					o.st = plc_pkg::ST_BAD_POS;
				end else if (rq == plc_pkg::REQ_READ) begin
					o.hdl = slots[ps-1];
				end else begin
					for (int i = ps - 1; i + 1 < held; i++)
						slots[i] = slots[i+1];
					held--;
				end
			end
			default: o.st = plc_pkg::ST_BAD_POS;
		endcase
		o.cnt = 7'(held);
		waiting.push_back(o);
	endfunction

	function void check(logic [1:0] st, logic [15:0] rh, logic [6:0] ec);
		outcome_t o;
		if (waiting.size() == 0) begin
			bad++;
			if (bad <= 10)
				$display("unexpected word: status %0d handle %h count %0d", st, rh, ec);
			return;
		end
		o = waiting.pop_front();
		if (st !== o.st || rh !== o.hdl || ec !== o.cnt) begin
			bad++;
			if (bad <= 10)
				$display("mismatch: status %0d/%0d handle %h/%h count %0d/%0d (exp/got)",
					o.st, st, o.hdl, rh, o.cnt, ec);
		end
	endfunction

endclass

module tb_positional_list_append_read_remove_top import plc_pkg::*;;

	localparam int          CAPACITY    = 64;
	localparam int          HANDLE_BITS = 16;
	localparam int          STALL_LIMIT = 4000;
	localparam logic [1:0]  REQ_UNUSED  = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  req_type;
	logic [7:0]  position;
	logic [15:0] item_handle;
	logic        done;
	logic [1:0]  status;
	logic [15:0] read_handle;
	logic [6:0]  entry_count;

	int stall_cycles;

	list_tracker #(CAPACITY, HANDLE_BITS) sb;

	positional_list_append_read_remove_top #(
		.CAPACITY    (CAPACITY),
		.HANDLE_BITS (HANDLE_BITS)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req_type    (req_type),
		.position    (position),
		.item_handle (item_handle),
		.done        (done),
		.status      (status),
		.read_handle (read_handle),
		.entry_count (entry_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				sb.note(req_type, position, item_handle);
			if (done)
				sb.check(status, read_handle, entry_count);
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic send(logic [1:0] rq, logic [7:0] ps, logic [15:0] hd, int idle_pct);
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		start       <= 1'b1;
		req_type    <= rq;
		position    <= ps;
		item_handle <= hd;
		do @(posedge clk); while (busy);
	endtask

	// hold off until every word in flight has come back
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.outstanding() != 0)
			@(posedge clk);
	endtask

	task automatic run_phase(int n, int idle_pct);
		int         bias;
		int         held;
		int         r;
		logic [1:0] rq;
		logic [7:0] ps;
		bias = 50;
		for (int k = 0; k < n; k++) begin
			if (k % 60 == 0) begin
				case ($urandom_range(2))
					0: bias = 90;
					1: bias = 50;
					default: bias = 15;
				endcase
			end
			held = sb.held;
			if ($urandom_range(99) < 3)
				rq = REQ_UNUSED;
			else if ($urandom_range(99) < bias)
				rq = REQ_APPEND;
			else if ($urandom_range(1) == 1)
				rq = REQ_READ;
			else
				rq = REQ_REMOVE;
			r = $urandom_range(9);
			if (held > 0 && r < 7)
				ps = 8'($urandom_range(held, 1));
			else if (r == 7)
				ps = 8'(held + 1);
			else if (r == 8)
				ps = 8'(($urandom_range(1) == 1) ? 255 : 0);
			else
				ps = 8'($urandom_range(255));
			send(rq, ps, 16'($urandom_range(16'hFFFF)), idle_pct);
		end
	endtask

	initial begin
		sb = new();
		arst_n      <= 1'b0;
		start       <= 1'b0;
		req_type    <= REQ_APPEND;
		position    <= 8'd0;
		item_handle <= 16'd0;
		stall_cycles = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(REQ_READ,   8'd1,   16'h1234, 0);
		send(REQ_REMOVE, 8'd0,   16'h0000, 0);
		send(REQ_APPEND, 8'd0,   16'h0000, 0);
		send(REQ_APPEND, 8'd255, 16'hFFFF, 0);
		send(REQ_APPEND, 8'd7,   16'h5A5A, 0);
		send(REQ_READ,   8'd0,   16'h0000, 0);
		send(REQ_READ,   8'd4,   16'h0000, 0);
		send(REQ_READ,   8'd255, 16'hFFFF, 0);
		send(REQ_READ,   8'd1,   16'h0000, 0);
		send(REQ_READ,   8'd3,   16'h0000, 0);
		send(REQ_REMOVE, 8'd2,   16'h0000, 0);
		send(REQ_READ,   8'd2,   16'h0000, 0);
		send(REQ_UNUSED, 8'd0,   16'hFFFF, 0);
		send(REQ_REMOVE, 8'd255, 16'h0000, 0);
		send(REQ_APPEND, 8'd0,   16'hA5A5, 0);
		send(REQ_REMOVE, 8'd3,   16'h0000, 0);
		send(REQ_REMOVE, 8'd1,   16'h0000, 0);
		send(REQ_REMOVE, 8'd1,   16'h0000, 0);
		send(REQ_READ,   8'd1,   16'h0000, 0);
		send(REQ_UNUSED, 8'd1,   16'h0000, 0);
		send(REQ_APPEND, 8'd0,   16'h8001, 0);
		send(REQ_READ,   8'd1,   16'h0000, 0);

		drain();
		run_phase(480, 7);
		drain();
		run_phase(480, 87);
		drain();
		run_phase(470, 0);
		drain();
		repeat (4) @(posedge clk);

		if (sb.bad == 0 && sb.outstanding() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
